>>> rtl/bds_pkg.sv
// shared types, constants and register codes of the 2x2 box downsampler
package bds_pkg;

  localparam int unsigned MAX_FRAME_WIDTH_DEF = 4096;
  localparam int unsigned MAX_OUT_SIZE_DEF    = 256;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned FW_W      = 13;
  localparam int unsigned WIN_W     = 12;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned OUT_IDX_W = 8;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_FRAME_WIDTH = 2'd0;
  localparam reg_idx_t REG_WINDOW_COL  = 2'd1;
  localparam reg_idx_t REG_WINDOW_ROW  = 2'd2;
  localparam reg_idx_t REG_OUT_SIZE    = 2'd3;

  localparam logic [FW_W-1:0]   FRAME_WIDTH_RST = 13'd64;
  localparam logic [WIN_W-1:0]  WINDOW_COL_RST  = 12'd0;
  localparam logic [WIN_W-1:0]  WINDOW_ROW_RST  = 12'd0;
  localparam logic [SIZE_W-1:0] OUT_SIZE_RST    = 9'd8;

  typedef struct packed {
    logic [FW_W-1:0]   frame_width;
    logic [WIN_W-1:0]  window_col;
    logic [WIN_W-1:0]  window_row;
    logic [SIZE_W-1:0] out_size;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]     avg_pixel;
    logic [OUT_IDX_W-1:0] out_col;
    logic [OUT_IDX_W-1:0] out_row;
    logic                 block_done;
  } result_t;

  // odd-row pair waiting for its line store partner
  typedef struct packed {
    logic [PIX_W:0]       pair;
    logic [OUT_IDX_W-1:0] out_col;
    logic [OUT_IDX_W-1:0] out_row;
    logic                 block_done;
  } pend_t;

endpackage

>>> rtl/bds_stream_if.sv
// valid/ready stream channel with a typed payload
interface bds_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/bds_cfg.sv
// apb register file for the window and frame settings
module bds_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bds_pkg::ADDR_W-1:0]  paddr,
  input  logic [bds_pkg::DATA_W-1:0]  pwdata,
  output logic [bds_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bds_pkg::cfg_t               cfg
);

  bds_pkg::reg_idx_t idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width <= bds_pkg::FRAME_WIDTH_RST;
      cfg.window_col  <= bds_pkg::WINDOW_COL_RST;
      cfg.window_row  <= bds_pkg::WINDOW_ROW_RST;
      cfg.out_size    <= bds_pkg::OUT_SIZE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        bds_pkg::REG_FRAME_WIDTH: cfg.frame_width <= pwdata[bds_pkg::FW_W-1:0];
        bds_pkg::REG_WINDOW_COL:  cfg.window_col  <= pwdata[bds_pkg::WIN_W-1:0];
        bds_pkg::REG_WINDOW_ROW:  cfg.window_row  <= pwdata[bds_pkg::WIN_W-1:0];
        bds_pkg::REG_OUT_SIZE:    cfg.out_size    <= pwdata[bds_pkg::SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bds_pkg::REG_FRAME_WIDTH: prdata = bds_pkg::DATA_W'(cfg.frame_width);
      bds_pkg::REG_WINDOW_COL:  prdata = bds_pkg::DATA_W'(cfg.window_col);
      bds_pkg::REG_WINDOW_ROW:  prdata = bds_pkg::DATA_W'(cfg.window_row);
      bds_pkg::REG_OUT_SIZE:    prdata = bds_pkg::DATA_W'(cfg.out_size);
    endcase
  end

endmodule

>>> rtl/bds_front.sv
// raster position tracking, window test, pair sums and the line store
module bds_front #(
  parameter int unsigned MAX_FRAME_WIDTH = bds_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int unsigned MAX_OUT_SIZE    = bds_pkg::MAX_OUT_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bds_pkg::cfg_t              cfg,
  input  bds_pkg::pixel_t            pix,
  input  logic                       pix_valid,
  output logic                       pix_ready,
  input  logic                       out_adv,
  output logic                       pend_valid,
  output bds_pkg::pend_t             pend,
  output logic [bds_pkg::PIX_W:0]    line_rd
);

  localparam int unsigned CW   = $clog2(MAX_FRAME_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int unsigned SZW  = $clog2(MAX_OUT_SIZE + 1);
  localparam int unsigned SPW  = SZW + 1;
  localparam int unsigned PW_A = (CW > bds_pkg::WIN_W) ? CW : bds_pkg::WIN_W;
  localparam int unsigned PW_B = (PW_A > SPW) ? PW_A : SPW;
  localparam int unsigned PW   = PW_B + 1;
  localparam int unsigned SLW  = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;

  logic [CW-1:0]                col;
  logic [CW-1:0]                col_next;
  logic [bds_pkg::ROW_W-1:0]    row;
  logic [bds_pkg::ROW_W-1:0]    row_next;
  logic [bds_pkg::PIX_W-1:0]    held_left;
  logic [bds_pkg::PIX_W:0]      line_mem [MAX_OUT_SIZE];

  logic [WW-1:0]                width_eff;
  logic [SZW-1:0]               size_eff;
  logic [CW-1:0]                c;
  logic [bds_pkg::ROW_W-1:0]    r;
  logic [PW-1:0]                wc;
  logic [PW-1:0]                wr;
  logic [PW-1:0]                span;
  logic [PW-1:0]                oc;
  logic [PW-1:0]                orow;
  logic [PW-1:0]                last_idx;
  logic [SLW-1:0]               slot;
  logic [bds_pkg::PIX_W:0]      pair;
  logic                         in_win;
  logic                         last_col;
  logic                         emit;
  logic                         store_en;
  logic                         in_fire;
  logic                         pend_en;

  assign pend_en   = !pend_valid || out_adv;
  assign pix_ready = pend_en;
  assign in_fire   = pix_valid && pix_ready;

  always_comb begin
    if (cfg.frame_width < bds_pkg::FW_W'(2)) begin
      width_eff = WW'(2);
    end else if (32'(cfg.frame_width) > 32'(MAX_FRAME_WIDTH)) begin
      width_eff = WW'(MAX_FRAME_WIDTH);
    end else begin
      width_eff = WW'(cfg.frame_width);
    end
    if (cfg.out_size == '0) begin
      size_eff = SZW'(1);
    end else if (32'(cfg.out_size) > 32'(MAX_OUT_SIZE)) begin
      size_eff = SZW'(MAX_OUT_SIZE);
    end else begin
      size_eff = SZW'(cfg.out_size);
    end
  end

  always_comb begin
    c        = pix.frame_start ? '0 : col;
    r        = pix.frame_start ? '0 : row;
    wc       = PW'(c) - PW'(cfg.window_col);
    wr       = PW'(r) - PW'(cfg.window_row);
    span     = PW'({size_eff, 1'b0});
    in_win   = (PW'(c) >= PW'(cfg.window_col)) && (wc < span) &&
               (PW'(r) >= PW'(cfg.window_row)) && (wr < span);
    oc       = wc >> 1;
    orow     = wr >> 1;
    last_idx = PW'(size_eff) - PW'(1);
    slot     = SLW'(oc & PW'(MAX_OUT_SIZE - 1));
    pair     = {1'b0, held_left} + {1'b0, pix.pixel_in};
    emit     = in_win && wc[0] && wr[0];
    store_en = in_fire && in_win && wc[0] && !wr[0];
    // column wraps at the effective frame width, row counter wraps on its own
    last_col = (WW'(c) + WW'(1)) >= width_eff;
    col_next = last_col ? '0 : CW'(c + CW'(1));
    row_next = last_col ? r + bds_pkg::ROW_W'(1) : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      held_left  <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        col <= col_next;
        row <= row_next;
        if (in_win && !wc[0]) begin
          held_left <= pix.pixel_in;
        end
      end
      if (pend_en) begin
        pend_valid <= in_fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_en) begin
      pend.pair       <= pair;
      pend.out_col    <= oc[bds_pkg::OUT_IDX_W-1:0];
      pend.out_row    <= orow[bds_pkg::OUT_IDX_W-1:0];
      pend.block_done <= (oc == last_idx) && (orow == last_idx);
    end
  end

  // even rows write pair sums, odd rows read them back into line_rd while the pending entry advances
  always_ff @(posedge clk) begin
    if (store_en) begin
      line_mem[slot] <= pair;
    end
    if (pend_en) begin
      line_rd <= line_mem[slot];
    end
  end

endmodule

>>> rtl/bds_avg.sv
// final 2x2 sum, divide by four and the result register
module bds_avg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pend_valid,
  input  bds_pkg::pend_t             pend,
  input  logic [bds_pkg::PIX_W:0]    line_rd,
  output logic                       out_adv,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bds_pkg::result_t           res
);

  logic [bds_pkg::PIX_W+1:0] sum4;

  assign out_adv = !res_valid || res_ready;
  assign sum4    = {1'b0, line_rd} + {1'b0, pend.pair};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_adv) begin
      res_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      res.avg_pixel  <= sum4[bds_pkg::PIX_W+1:2];
      res.out_col    <= pend.out_col;
      res.out_row    <= pend.out_row;
      res.block_done <= pend.block_done;
    end
  end

endmodule

>>> rtl/box_downsample_2x2.sv
// the pair sum of an odd-row right pixel is registered as the pending entry; a result stall holds it there
// throughput: one pixel per cycle unless the result side stalls, set by the single line store access per pixel
// the line store read is registered, then the 2x2 sum lands in the result register
// reset: position counters, held left pixel, valid flags and registers go to defaults
// the line store is not cleared; even rows fill it before odd rows read it
module box_downsample_2x2 #(
  parameter int unsigned MAX_FRAME_WIDTH = bds_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int unsigned MAX_OUT_SIZE    = bds_pkg::MAX_OUT_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bds_pkg::ADDR_W-1:0] paddr,
  input  logic [bds_pkg::DATA_W-1:0] pwdata,
  output logic [bds_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  bds_stream_if.sink                 pixel,
  bds_stream_if.source               result
);

  bds_pkg::cfg_t             cfg;
  bds_pkg::pend_t            pend;
  logic                      pend_valid;
  logic                      out_adv;
  logic [bds_pkg::PIX_W:0]   line_rd;
  bds_pkg::pixel_t           pix;
  bds_pkg::result_t          res;

  assign pix         = pixel.data;
  assign result.data = res;

  bds_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bds_front #(
    .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
    .MAX_OUT_SIZE    (MAX_OUT_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix        (pix),
    .pix_valid  (pixel.valid),
    .pix_ready  (pixel.ready),
    .out_adv    (out_adv),
    .pend_valid (pend_valid),
    .pend       (pend),
    .line_rd    (line_rd)
  );

  bds_avg u_avg (
    .clk        (clk),
    .rst        (rst),
    .pend_valid (pend_valid),
    .pend       (pend),
    .line_rd    (line_rd),
    .out_adv    (out_adv),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res        (res)
  );

endmodule

>>> tb/sv/bds_avg_checker.sv
`timescale 1ns / 100ps
// checker for the 2x2 box downsampler: tracks registers, predicts block averages, compares results
module bds_avg_checker
  import bds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pixel_valid,
  input  logic              pixel_ready,
  input  pixel_t            pixel_data,
  input  logic              result_valid,
  input  logic              result_ready,
  input  result_t           result_data,
  output int unsigned       error_count,
  output int unsigned       avg_pending
);

  localparam int unsigned ROW_WRAP = 2 ** ROW_W;

  cfg_t             cfg;
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  logic [PIX_W-1:0] left_pix;
  logic [PIX_W:0]   pair_line [MAX_OUT_SIZE_DEF];
  result_t          avg_due [$];
  result_t          want_res;

  initial error_count = 0;

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // one pixel through the window logic; an odd-row right pixel yields a block average
  task automatic predict_box_avg(input pixel_t px);
    int unsigned width, size, span, c, r, wc, wr, slot, pair, oc, orow;
    result_t res;
    width = (cfg.frame_width < 2) ? 2 :
            (cfg.frame_width > MAX_FRAME_WIDTH_DEF) ? MAX_FRAME_WIDTH_DEF : cfg.frame_width;
    size = (cfg.out_size < 1) ? 1 :
           (cfg.out_size > MAX_OUT_SIZE_DEF) ? MAX_OUT_SIZE_DEF : cfg.out_size;
    span = 2 * size;
    if (px.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    if (c >= cfg.window_col && c - cfg.window_col < span &&
        r >= cfg.window_row && r - cfg.window_row < span) begin
      wc = c - cfg.window_col;
      wr = r - cfg.window_row;
      slot = (wc / 2) % MAX_OUT_SIZE_DEF;
      if (wc % 2 == 0) begin
        left_pix = px.pixel_in;
      end else begin
        pair = left_pix + px.pixel_in;
        if (wr % 2 == 0) begin
          pair_line[slot] = pair[PIX_W:0];
        end else begin
          oc = wc / 2;
          orow = wr / 2;
          res.avg_pixel = PIX_W'((pair_line[slot] + pair) >> 2);
          res.out_col = OUT_IDX_W'(oc);
          res.out_row = OUT_IDX_W'(orow);
          res.block_done = (oc == size - 1) && (orow == size - 1);
          avg_due.push_back(res);
        end
      end
    end
    if (c + 1 >= width) begin
      col_cnt = 0;
      row_cnt = (r + 1) % ROW_WRAP;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = '{frame_width: FRAME_WIDTH_RST, window_col: WINDOW_COL_RST,
              window_row: WINDOW_ROW_RST, out_size: OUT_SIZE_RST};
      col_cnt = 0;
      row_cnt = 0;
      left_pix = '0;
      foreach (pair_line[i]) pair_line[i] = '0;
      avg_due.delete();
    end else begin
      // results first: a pixel taken at this edge cannot have produced one yet
      if (result_valid && result_ready) begin
        if (avg_due.size() == 0) begin
          $error("result with none expected: avg_pixel %0d out_col %0d out_row %0d block_done %0d",
                 result_data.avg_pixel, result_data.out_col, result_data.out_row,
                 result_data.block_done);
          error_count++;
        end else begin
          want_res = avg_due.pop_front();
          check_field("avg_pixel", want_res.avg_pixel, result_data.avg_pixel);
          check_field("out_col", want_res.out_col, result_data.out_col);
          check_field("out_row", want_res.out_row, result_data.out_row);
          check_field("block_done", {7'b0, want_res.block_done}, {7'b0, result_data.block_done});
        end
      end
      if (pixel_valid && pixel_ready) predict_box_avg(pixel_data);
      // register writes apply from the next pixel on
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_FRAME_WIDTH: cfg.frame_width = pwdata[FW_W-1:0];
          REG_WINDOW_COL:  cfg.window_col = pwdata[WIN_W-1:0];
          REG_WINDOW_ROW:  cfg.window_row = pwdata[WIN_W-1:0];
          REG_OUT_SIZE:    cfg.out_size = pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
    avg_pending <= avg_due.size();
  end

endmodule

>>> tb/sv/tb_box_downsample_2x2.sv
`timescale 1ns / 100ps
// testbench top for the 2x2 box downsampler: clock, reset, register setup and pixel frames
module tb_box_downsample_2x2;
  import bds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RANDOM_PIXELS_PER_PHASE = 300;
  localparam int unsigned LATENCY_GUARD = 4;

  typedef enum {FILL_RANDOM, FILL_BLACK, FILL_WHITE} fill_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pixels_sent = 0;
  int unsigned error_count;
  int unsigned avg_pending;

  bds_stream_if #(.payload_t(pixel_t))  pixel_ch ();
  bds_stream_if #(.payload_t(result_t)) result_ch ();

  box_downsample_2x2 i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixel   (pixel_ch),
    .result  (result_ch)
  );

  bds_avg_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pixel_valid  (pixel_ch.valid),
    .pixel_ready  (pixel_ch.ready),
    .pixel_data   (pixel_ch.data),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .result_data  (result_ch.data),
    .error_count  (error_count),
    .avg_pending  (avg_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      pixel_ch.data <= '{pixel_in: PIX_W'($urandom), frame_start: 1'($urandom)};
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.data <= '{pixel_in: pix, frame_start: first};
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input fill_t fill, input logic restart);
    logic [PIX_W-1:0] pix;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_BLACK: pix = '0;
        FILL_WHITE: pix = '1;
        default:    pix = PIX_W'($urandom_range(255));
      endcase
      send_pixel(pix, restart && i == 0);
    end
  endtask

  // one 2x2 block as a whole frame of width 2
  task automatic send_quad(input logic [PIX_W-1:0] a, b, c, d);
    send_pixel(a, 1'b1);
    send_pixel(b, 1'b0);
    send_pixel(c, 1'b0);
    send_pixel(d, 1'b0);
  endtask

  // stop sending and wait until every predicted average has come out
  task automatic settle();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (avg_pending != 0) @(posedge clk);
    repeat (LATENCY_GUARD) @(posedge clk);
  endtask

  // psel stays high between back-to-back writes; configure drops it after the last one
  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] fw, col, row, size);
    settle();
    reg_write(REG_FRAME_WIDTH, fw);
    reg_write(REG_WINDOW_COL, col);
    reg_write(REG_WINDOW_ROW, row);
    reg_write(REG_OUT_SIZE, size);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // small frames with the window mostly inside, sometimes past the right edge
  task automatic random_setup(output int unsigned frame_len);
    int unsigned w_eff, w_raw, s_eff, s_raw, col, row;
    w_eff = $urandom_range(2, 16);
    w_raw = w_eff;
    if ($urandom_range(9) == 0) begin
      w_eff = 2;
      w_raw = $urandom_range(1);
    end
    s_eff = $urandom_range(1, (w_eff / 2 < 4) ? w_eff / 2 : 4);
    s_raw = s_eff;
    if ($urandom_range(9) == 0) begin
      s_eff = 1;
      s_raw = 0;
    end
    if ($urandom_range(4) == 0) col = $urandom_range(0, w_eff + 1);
    else col = $urandom_range(0, w_eff - 2 * s_eff);
    row = $urandom_range(0, 2);
    frame_len = w_eff * (row + 2 * s_eff) + $urandom_range(0, w_eff);
    configure(w_raw, col, row, s_raw);
  endtask

  initial begin : stimulus
    int unsigned phase_start, frame_len, len;
    fill_t fill;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset registers: 64 wide frame, top rows of the 8x8 output block at the origin
    send_frame(64 * 4, FILL_RANDOM, 1'b1);

    configure(2, 0, 0, 1);
    send_quad(8'd0, 8'd0, 8'd0, 8'd0);
    send_quad(8'd255, 8'd255, 8'd255, 8'd255);
    send_quad(8'd255, 8'd255, 8'd255, 8'd254);
    send_quad(8'd3, 8'd0, 8'd0, 8'd0);
    send_quad(8'd128, 8'd64, 8'd32, 8'd16);

    // zero width and zero size act as the minimum
    configure(0, 0, 0, 0);
    send_quad(8'd200, 8'd100, 8'd50, 8'd25);

    // all-ones size clamps to the largest output block, cut by a narrow frame
    configure(8, 0, 0, 32'hffff_ffff);
    send_frame(8 * 4, FILL_RANDOM, 1'b1);

    // window origin beyond anything reached
    configure(5, 32'hffff_ffff, 32'hffff_ffff, 1);
    send_frame(20, FILL_WHITE, 1'b1);

    // window hangs past the right edge: only the first two output columns appear
    configure(10, 6, 1, 4);
    send_frame(90, FILL_RANDOM, 1'b1);

    // window moved mid-frame: the next right pixel pairs with a stale left pixel
    configure(4, 0, 0, 2);
    send_frame(6, FILL_RANDOM, 1'b1);
    configure(4, 1, 0, 2);
    send_frame(10, FILL_RANDOM, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 66 : (phase == 3) ? 16 : 0;
      recv_stall_pct = (phase == 2) ? 66 : (phase == 3) ? 16 : 0;
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < RANDOM_PIXELS_PER_PHASE) begin
        random_setup(frame_len);
        repeat ($urandom_range(1, 3)) begin
          // a cut frame is followed by a fresh frame start
          len = ($urandom_range(7) == 0) ? $urandom_range(1, frame_len) : frame_len;
          case ($urandom_range(9))
            0:       fill = FILL_BLACK;
            1:       fill = FILL_WHITE;
            default: fill = FILL_RANDOM;
          endcase
          send_frame(len, fill, 1'b1);
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
